[src/i2c_mra_pkg.sv]
// ----------------------------------------------------------------------------
// I2C master register access package
// Shared widths, register indexes, primitive codes and the command scripts.
// ----------------------------------------------------------------------------
`default_nettype none

package i2c_mra_pkg;

  localparam int unsigned ActW    = 3;
  localparam int unsigned StepW   = 4;
  localparam int unsigned DelayW  = 24;
  localparam int unsigned InW     = 24;
  localparam int unsigned OutW    = 16;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 16;

  localparam logic [StepW-1:0] ScriptLen = 4'd10;
  localparam logic [StepW-1:0] AbortStep = 4'd15;

  localparam logic [CfgIdxW-1:0] CfgTicksPerUnit  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgAckPollLimit  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgDeviceAddress = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgWriteRecovery = 2'd3;

  typedef enum logic [ActW-1:0] {
    ACT_NONE      = 3'd0,
    ACT_START     = 3'd1,
    ACT_STOP      = 3'd2,
    ACT_WRITE     = 3'd3,
    ACT_READ      = 3'd4,
    ACT_REG_READ  = 3'd5,
    ACT_REG_WRITE = 3'd6,
    ACT_UNUSED    = 3'd7
  } action_e;

  typedef enum logic [3:0] {
    OP_END        = 4'd0,
    OP_START      = 4'd1,
    OP_STOP       = 4'd2,
    OP_SEND_AW    = 4'd3,
    OP_SEND_AR    = 4'd4,
    OP_SEND_REG   = 4'd5,
    OP_SEND_DATA  = 4'd6,
    OP_WAIT       = 4'd7,
    OP_READ_ACKIN = 4'd8,
    OP_READ_NACK  = 4'd9,
    OP_RECOVER    = 4'd10
  } op_e;

  function automatic op_e script_op(input logic [ActW-1:0] act,
                                    input logic [StepW-1:0] step);
    op_e op;
    op = OP_END;
    case (act)
      ACT_START: begin
        if (step == 4'd0) op = OP_START;
      end
      ACT_STOP: begin
        if (step == 4'd0) op = OP_STOP;
      end
      ACT_WRITE: begin
        case (step)
          4'd0:    op = OP_SEND_DATA;
          4'd1:    op = OP_WAIT;
          default: op = OP_END;
        endcase
      end
      ACT_READ: begin
        if (step == 4'd0) op = OP_READ_ACKIN;
      end
      ACT_REG_READ: begin
        case (step)
          4'd0:    op = OP_START;
          4'd1:    op = OP_SEND_AW;
          4'd2:    op = OP_WAIT;
          4'd3:    op = OP_SEND_REG;
          4'd4:    op = OP_WAIT;
          4'd5:    op = OP_START;
          4'd6:    op = OP_SEND_AR;
          4'd7:    op = OP_WAIT;
          4'd8:    op = OP_READ_NACK;
          4'd9:    op = OP_STOP;
          default: op = OP_END;
        endcase
      end
      ACT_REG_WRITE: begin
        case (step)
          4'd0:    op = OP_START;
          4'd1:    op = OP_SEND_AW;
          4'd2:    op = OP_WAIT;
          4'd3:    op = OP_SEND_REG;
          4'd4:    op = OP_WAIT;
          4'd5:    op = OP_SEND_DATA;
          4'd6:    op = OP_WAIT;
          4'd7:    op = OP_STOP;
          4'd8:    op = OP_RECOVER;
          default: op = OP_END;
        endcase
      end
      default: op = OP_END;
    endcase
    return op;
  endfunction

endpackage

`default_nettype wire

[src/i2c_master_register_access.sv]
// ----------------------------------------------------------------------------
// I2C master register access
// Tick-driven I2C bus master with byte primitives and register transactions.
// ----------------------------------------------------------------------------
// Each input transfer is one timebase tick carrying an optional command and the
// sampled SDA level, and each tick yields exactly one output transfer with the
// driven SCL, SDA and SDA enable levels and the status. One tick is processed
// per clock cycle: the sequencer state and the output register are updated in
// a single pass, and a new tick is taken whenever the output register is empty
// or being drained in the same cycle. Commands arriving while busy are ignored.
`default_nettype none

module i2c_master_register_access (
  input  wire  logic                                clk_i,
  input  wire  logic                                rst_ni,
  input  wire  logic                                cfg_we_i,
  input  wire  logic [i2c_mra_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire  logic [i2c_mra_pkg::CfgW-1:0]        cfg_data_i,
  input  wire  logic                                s_axis_tvalid,
  output logic                                      s_axis_tready,
  // action[2:0], data_byte[10:3], reg_address[18:11], ack_after_read[19],
  // sda_in[20], zero fill.
  input  wire  logic [i2c_mra_pkg::InW-1:0]         s_axis_tdata,
  output logic                                      m_axis_tvalid,
  input  wire  logic                                m_axis_tready,
  // scl_out[0], sda_out[1], sda_drive[2], busy_res[3], done_res[4],
  // read_data[12:5], ack_error[13], zero fill.
  output logic [i2c_mra_pkg::OutW-1:0]              m_axis_tdata
);

  typedef enum logic [4:0] {
    PH_IDLE = 5'd0,
    PH_ST0  = 5'd1,
    PH_ST1  = 5'd2,
    PH_ST2  = 5'd3,
    PH_SP0  = 5'd4,
    PH_SP1  = 5'd5,
    PH_SP2  = 5'd6,
    PH_SB1  = 5'd7,
    PH_SB2  = 5'd8,
    PH_SB3  = 5'd9,
    PH_WA0  = 5'd10,
    PH_WA1  = 5'd11,
    PH_WA2  = 5'd12,
    PH_RB0  = 5'd13,
    PH_RB1  = 5'd14,
    PH_RB2  = 5'd15,
    PH_RB3  = 5'd16,
    PH_RB4  = 5'd17,
    PH_RC0  = 5'd18,
    PH_RC1  = 5'd19
  } phase_e;

  logic [7:0]  tpu_q, poll_lim_q;
  logic [6:0]  dev_addr_q;
  logic [15:0] wr_rec_q;

  phase_e                            phase_q, phase_d;
  logic [i2c_mra_pkg::StepW-1:0]     step_q, step_d;
  logic [i2c_mra_pkg::ActW-1:0]      pend_q, pend_d;
  logic [3:0]                        bit_cnt_q, bit_cnt_d;
  logic [7:0]                        shift_q, shift_d;
  logic [i2c_mra_pkg::DelayW-1:0]    delay_q, delay_d;
  logic [7:0]                        poll_q, poll_d;
  logic [7:0]                        rx_q, rx_d;
  logic                              err_q, err_d;
  logic                              scl_q, scl_d, sda_q, sda_d, drv_q, drv_d;
  logic [7:0]                        lat_data_q, lat_data_d, lat_reg_q, lat_reg_d;
  logic                              lat_ack_q, lat_ack_d, rd_ack_q, rd_ack_d;
  logic                              out_valid_q;
  logic [i2c_mra_pkg::OutW-1:0]      out_data_q;

  logic [i2c_mra_pkg::ActW-1:0]      in_act;
  logic [7:0]                        in_data, in_reg;
  logic                              in_ack, in_sda;
  logic                              in_fire;
  logic                              done;
  logic                              do_adv, do_begin, do_finish, do_wait;
  logic [15:0]                       wait_u;
  logic [3:0]                        bit_inc;
  i2c_mra_pkg::op_e                  op;

  assign in_act  = s_axis_tdata[2:0];
  assign in_data = s_axis_tdata[10:3];
  assign in_reg  = s_axis_tdata[18:11];
  assign in_ack  = s_axis_tdata[19];
  assign in_sda  = s_axis_tdata[20];

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign bit_inc       = bit_cnt_q + 4'd1;

  always_comb begin
    phase_d    = phase_q;
    step_d     = step_q;
    pend_d     = pend_q;
    bit_cnt_d  = bit_cnt_q;
    shift_d    = shift_q;
    delay_d    = delay_q;
    poll_d     = poll_q;
    rx_d       = rx_q;
    err_d      = err_q;
    scl_d      = scl_q;
    sda_d      = sda_q;
    drv_d      = drv_q;
    lat_data_d = lat_data_q;
    lat_reg_d  = lat_reg_q;
    lat_ack_d  = lat_ack_q;
    rd_ack_d   = rd_ack_q;
    do_adv     = 1'b0;
    do_begin   = 1'b0;
    do_finish  = 1'b0;
    do_wait    = 1'b0;
    wait_u     = 16'd0;
    op         = i2c_mra_pkg::OP_END;

    if (phase_q == PH_IDLE) begin
      if (in_act != i2c_mra_pkg::ACT_NONE && in_act != i2c_mra_pkg::ACT_UNUSED) begin
        pend_d     = in_act;
        lat_data_d = in_data;
        lat_reg_d  = in_reg;
        lat_ack_d  = in_ack;
        err_d      = 1'b0;
        step_d     = '0;
        delay_d    = '0;
        do_begin   = 1'b1;
      end
    end else if (delay_q != '0) begin
      delay_d = delay_q - 1'b1;
    end else begin
      case (phase_q)
        PH_ST0: begin
          drv_d = 1'b1; sda_d = 1'b1; scl_d = 1'b1;
          do_wait = 1'b1; wait_u = 16'd4; phase_d = PH_ST1;
        end
        PH_ST1: begin
          sda_d = 1'b0; do_wait = 1'b1; wait_u = 16'd4; phase_d = PH_ST2;
        end
        PH_ST2: begin
          scl_d = 1'b0; do_adv = 1'b1;
        end
        PH_SP0: begin
          drv_d = 1'b1; scl_d = 1'b0; sda_d = 1'b0;
          do_wait = 1'b1; wait_u = 16'd4; phase_d = PH_SP1;
        end
        PH_SP1: begin
          scl_d = 1'b1; sda_d = 1'b1;
          do_wait = 1'b1; wait_u = 16'd4; phase_d = PH_SP2;
        end
        PH_SP2: do_adv = 1'b1;
        PH_SB1: begin
          drv_d = 1'b1; scl_d = 1'b0; sda_d = shift_q[7];
          shift_d = {shift_q[6:0], 1'b0};
          do_wait = 1'b1; wait_u = 16'd2; phase_d = PH_SB2;
        end
        PH_SB2: begin
          scl_d = 1'b1; do_wait = 1'b1; wait_u = 16'd2; phase_d = PH_SB3;
        end
        PH_SB3: begin
          scl_d = 1'b0; do_wait = 1'b1; wait_u = 16'd2;
          bit_cnt_d = bit_inc;
          if (bit_inc < 4'd8) begin
            phase_d = PH_SB1;
          end else begin
            do_adv = 1'b1;
          end
        end
        PH_WA0: begin
          drv_d = 1'b0; sda_d = 1'b1;
          do_wait = 1'b1; wait_u = 16'd1; phase_d = PH_WA1;
        end
        PH_WA1: begin
          scl_d = 1'b1; do_wait = 1'b1; wait_u = 16'd1;
          poll_d = '0; phase_d = PH_WA2;
        end
        PH_WA2: begin
          if (!in_sda) begin
            scl_d = 1'b0; do_adv = 1'b1;
          end else if (poll_q >= poll_lim_q) begin
            err_d = 1'b1; step_d = i2c_mra_pkg::AbortStep; phase_d = PH_SP0;
          end else begin
            poll_d = poll_q + 8'd1;
          end
        end
        PH_RB0: begin
          drv_d = 1'b0; scl_d = 1'b0;
          do_wait = 1'b1; wait_u = 16'd2; phase_d = PH_RB1;
        end
        PH_RB1: begin
          scl_d = 1'b1; shift_d = {shift_q[6:0], in_sda};
          do_wait = 1'b1; wait_u = 16'd1; bit_cnt_d = bit_inc;
          phase_d = (bit_inc < 4'd8) ? PH_RB0 : PH_RB2;
        end
        PH_RB2: begin
          rx_d = shift_q; scl_d = 1'b0; drv_d = 1'b1; sda_d = !rd_ack_q;
          do_wait = 1'b1; wait_u = 16'd2; phase_d = PH_RB3;
        end
        PH_RB3: begin
          scl_d = 1'b1; do_wait = 1'b1; wait_u = 16'd2; phase_d = PH_RB4;
        end
        PH_RB4: begin
          scl_d = 1'b0; do_adv = 1'b1;
        end
        PH_RC0: begin
          do_wait = 1'b1; wait_u = wr_rec_q; phase_d = PH_RC1;
        end
        PH_RC1: do_adv = 1'b1;
        default: do_finish = 1'b1;
      endcase
    end

    if (do_wait) begin
      delay_d = {8'd0, wait_u} * {16'd0, tpu_q};
    end

    if (do_adv) begin
      if (step_q == i2c_mra_pkg::AbortStep) begin
        do_finish = 1'b1;
      end else begin
        step_d   = step_q + 4'd1;
        do_begin = 1'b1;
      end
    end

    if (do_begin) begin
      if (step_d >= i2c_mra_pkg::ScriptLen) begin
        do_finish = 1'b1;
      end else begin
        op        = i2c_mra_pkg::script_op(pend_d, step_d);
        bit_cnt_d = '0;
        case (op)
          i2c_mra_pkg::OP_START:      phase_d = PH_ST0;
          i2c_mra_pkg::OP_STOP:       phase_d = PH_SP0;
          i2c_mra_pkg::OP_SEND_AW: begin
            shift_d = {dev_addr_q, 1'b0}; phase_d = PH_SB1;
          end
          i2c_mra_pkg::OP_SEND_AR: begin
            shift_d = {dev_addr_q, 1'b1}; phase_d = PH_SB1;
          end
          i2c_mra_pkg::OP_SEND_REG: begin
            shift_d = lat_reg_d; phase_d = PH_SB1;
          end
          i2c_mra_pkg::OP_SEND_DATA: begin
            shift_d = lat_data_d; phase_d = PH_SB1;
          end
          i2c_mra_pkg::OP_WAIT:       phase_d = PH_WA0;
          i2c_mra_pkg::OP_READ_ACKIN: begin
            rd_ack_d = lat_ack_d; shift_d = '0; phase_d = PH_RB0;
          end
          i2c_mra_pkg::OP_READ_NACK: begin
            rd_ack_d = 1'b0; shift_d = '0; phase_d = PH_RB0;
          end
          i2c_mra_pkg::OP_RECOVER:    phase_d = PH_RC0;
          default:                    do_finish = 1'b1;
        endcase
      end
    end

    if (do_finish) begin
      phase_d = PH_IDLE;
      pend_d  = '0;
      step_d  = '0;
    end
  end

  assign done = do_finish;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpu_q       <= 8'd1;
      poll_lim_q  <= 8'd250;
      dev_addr_q  <= 7'd81;
      wr_rec_q    <= 16'd10000;
      phase_q     <= PH_IDLE;
      step_q      <= '0;
      pend_q      <= '0;
      bit_cnt_q   <= '0;
      shift_q     <= '0;
      delay_q     <= '0;
      poll_q      <= '0;
      rx_q        <= '0;
      err_q       <= 1'b0;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      drv_q       <= 1'b1;
      lat_data_q  <= '0;
      lat_reg_q   <= '0;
      lat_ack_q   <= 1'b0;
      rd_ack_q    <= 1'b0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          i2c_mra_pkg::CfgTicksPerUnit:  tpu_q      <= cfg_data_i[7:0];
          i2c_mra_pkg::CfgAckPollLimit:  poll_lim_q <= cfg_data_i[7:0];
          i2c_mra_pkg::CfgDeviceAddress: dev_addr_q <= cfg_data_i[6:0];
          i2c_mra_pkg::CfgWriteRecovery: wr_rec_q   <= cfg_data_i;
          default: ;
        endcase
      end
      if (in_fire) begin
        phase_q     <= phase_d;
        step_q      <= step_d;
        pend_q      <= pend_d;
        bit_cnt_q   <= bit_cnt_d;
        shift_q     <= shift_d;
        delay_q     <= delay_d;
        poll_q      <= poll_d;
        rx_q        <= rx_d;
        err_q       <= err_d;
        scl_q       <= scl_d;
        sda_q       <= sda_d;
        drv_q       <= drv_d;
        lat_data_q  <= lat_data_d;
        lat_reg_q   <= lat_reg_d;
        lat_ack_q   <= lat_ack_d;
        rd_ack_q    <= rd_ack_d;
        out_valid_q <= 1'b1;
        out_data_q  <= {2'b00, err_d, rx_d, done, (phase_d != PH_IDLE),
                        drv_d, sda_d, scl_d};
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

[dv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// I2C master register access testbench
// Drives one timebase tick per input transfer and checks every output transfer
// against a cycle-exact model of the bus sequencer kept in the testbench. The
// run covers every command, acknowledge timeouts, the poll limit extremes, a
// slow timebase, random register transactions and output back-pressure.
// ----------------------------------------------------------------------------

module testbench;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned ItemTarget = 1550;

  typedef enum logic [4:0] {
    SQ_IDLE, SQ_START_HI, SQ_START_SDA, SQ_START_SCL,
    SQ_STOP_LO, SQ_STOP_HI, SQ_STOP_END,
    SQ_BIT_SET, SQ_BIT_RISE, SQ_BIT_FALL,
    SQ_ACK_REL, SQ_ACK_RISE, SQ_ACK_POLL,
    SQ_RD_LOW, SQ_RD_RISE, SQ_RD_DONE, SQ_RD_ACKHI, SQ_RD_END,
    SQ_REC_WAIT, SQ_REC_END
  } seq_e;

  typedef struct {
    i2c_mra_pkg::action_e act;
    logic [7:0]           data;
    logic [7:0]           regaddr;
    logic                 ack;
    logic                 sda;
  } tick_t;

  typedef struct {
    logic       scl, sda, drv, busy, done;
    logic [7:0] rdata;
    logic       aerr;
  } line_status_t;

  logic                               clk_i = 1'b0;
  logic                               rst_ni;
  logic                               cfg_we_i;
  logic [i2c_mra_pkg::CfgIdxW-1:0]    cfg_idx_i;
  logic [i2c_mra_pkg::CfgW-1:0]       cfg_data_i;
  logic                               s_axis_tvalid;
  logic                               s_axis_tready;
  logic [i2c_mra_pkg::InW-1:0]        s_axis_tdata;
  logic                               m_axis_tvalid;
  logic                               m_axis_tready;
  logic [i2c_mra_pkg::OutW-1:0]       m_axis_tdata;

  line_status_t line_status_due[$];
  int unsigned  errors = 0;
  int unsigned  ticks_sent = 0;
  int unsigned  cycle_count = 0;
  int unsigned  hold_off = 0;
  bit           src_gaps = 1'b1;
  bit           sink_stalls = 1'b1;

  logic [7:0]           cfg_tpu, cfg_poll_limit;
  logic [6:0]           cfg_dev_addr;
  logic [15:0]          cfg_recovery;
  seq_e                 seq_state;
  i2c_mra_pkg::action_e cur_cmd;
  logic [3:0]           step_idx, bit_idx;
  logic [7:0]           shifter, poll_cnt, rx_byte, op_data, op_reg;
  logic [31:0]          hold_ticks;
  logic                 op_ack, ack_to_send, ack_err, drv_scl, drv_sda, drv_en, cmd_done;

  i2c_master_register_access dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
  end

  function automatic i2c_mra_pkg::op_e script_entry(input i2c_mra_pkg::action_e act,
                                                    input logic [3:0] step);
    logic [39:0] ops;
    ops = '0;
    case (act)
      i2c_mra_pkg::ACT_START:     ops[3:0] = i2c_mra_pkg::OP_START;
      i2c_mra_pkg::ACT_STOP:      ops[3:0] = i2c_mra_pkg::OP_STOP;
      i2c_mra_pkg::ACT_WRITE:     ops[7:0] = {i2c_mra_pkg::OP_WAIT,
                                              i2c_mra_pkg::OP_SEND_DATA};
      i2c_mra_pkg::ACT_READ:      ops[3:0] = i2c_mra_pkg::OP_READ_ACKIN;
      i2c_mra_pkg::ACT_REG_READ:  ops = {i2c_mra_pkg::OP_STOP, i2c_mra_pkg::OP_READ_NACK,
                                         i2c_mra_pkg::OP_WAIT, i2c_mra_pkg::OP_SEND_AR,
                                         i2c_mra_pkg::OP_START, i2c_mra_pkg::OP_WAIT,
                                         i2c_mra_pkg::OP_SEND_REG, i2c_mra_pkg::OP_WAIT,
                                         i2c_mra_pkg::OP_SEND_AW, i2c_mra_pkg::OP_START};
      i2c_mra_pkg::ACT_REG_WRITE: ops = {i2c_mra_pkg::OP_END, i2c_mra_pkg::OP_RECOVER,
                                         i2c_mra_pkg::OP_STOP, i2c_mra_pkg::OP_WAIT,
                                         i2c_mra_pkg::OP_SEND_DATA, i2c_mra_pkg::OP_WAIT,
                                         i2c_mra_pkg::OP_SEND_REG, i2c_mra_pkg::OP_WAIT,
                                         i2c_mra_pkg::OP_SEND_AW, i2c_mra_pkg::OP_START};
      default: ;
    endcase
    if (step >= i2c_mra_pkg::ScriptLen) begin
      return i2c_mra_pkg::OP_END;
    end
    return i2c_mra_pkg::op_e'(ops[step*4 +: 4]);
  endfunction

  function automatic void wait_units(input logic [31:0] units);
    hold_ticks = units * {24'd0, cfg_tpu};
  endfunction

  function automatic void end_cmd();
    seq_state = SQ_IDLE;
    cur_cmd   = i2c_mra_pkg::ACT_NONE;
    step_idx  = '0;
    cmd_done  = 1'b1;
  endfunction

  function automatic void begin_op();
    i2c_mra_pkg::op_e op;
    op = script_entry(cur_cmd, step_idx);
    bit_idx = '0;
    case (op)
      i2c_mra_pkg::OP_START:      seq_state = SQ_START_HI;
      i2c_mra_pkg::OP_STOP:       seq_state = SQ_STOP_LO;
      i2c_mra_pkg::OP_SEND_AW: begin
        shifter = {cfg_dev_addr, 1'b0};
        seq_state = SQ_BIT_SET;
      end
      i2c_mra_pkg::OP_SEND_AR: begin
        shifter = {cfg_dev_addr, 1'b1};
        seq_state = SQ_BIT_SET;
      end
      i2c_mra_pkg::OP_SEND_REG: begin
        shifter = op_reg;
        seq_state = SQ_BIT_SET;
      end
      i2c_mra_pkg::OP_SEND_DATA: begin
        shifter = op_data;
        seq_state = SQ_BIT_SET;
      end
      i2c_mra_pkg::OP_WAIT:       seq_state = SQ_ACK_REL;
      i2c_mra_pkg::OP_READ_ACKIN: begin
        ack_to_send = op_ack;
        shifter = '0;
        seq_state = SQ_RD_LOW;
      end
      i2c_mra_pkg::OP_READ_NACK: begin
        ack_to_send = 1'b0;
        shifter = '0;
        seq_state = SQ_RD_LOW;
      end
      i2c_mra_pkg::OP_RECOVER:    seq_state = SQ_REC_WAIT;
      default:                    end_cmd();
    endcase
  endfunction

  function automatic void next_op();
    if (step_idx == i2c_mra_pkg::AbortStep) begin
      end_cmd();
    end else begin
      step_idx = step_idx + 4'd1;
      begin_op();
    end
  endfunction

  function automatic void run_seq(input logic sda_in);
    case (seq_state)
      SQ_START_HI: begin
        drv_en = 1'b1; drv_sda = 1'b1; drv_scl = 1'b1;
        wait_units(4); seq_state = SQ_START_SDA;
      end
      SQ_START_SDA: begin
        drv_sda = 1'b0; wait_units(4); seq_state = SQ_START_SCL;
      end
      SQ_START_SCL: begin
        drv_scl = 1'b0; next_op();
      end
      SQ_STOP_LO: begin
        drv_en = 1'b1; drv_scl = 1'b0; drv_sda = 1'b0;
        wait_units(4); seq_state = SQ_STOP_HI;
      end
      SQ_STOP_HI: begin
        drv_scl = 1'b1; drv_sda = 1'b1; wait_units(4); seq_state = SQ_STOP_END;
      end
      SQ_STOP_END: next_op();
      SQ_BIT_SET: begin
        drv_en = 1'b1; drv_scl = 1'b0; drv_sda = shifter[7];
        shifter = {shifter[6:0], 1'b0};
        wait_units(2); seq_state = SQ_BIT_RISE;
      end
      SQ_BIT_RISE: begin
        drv_scl = 1'b1; wait_units(2); seq_state = SQ_BIT_FALL;
      end
      SQ_BIT_FALL: begin
        drv_scl = 1'b0; wait_units(2);
        bit_idx = bit_idx + 4'd1;
        if (bit_idx < 4'd8) begin
          seq_state = SQ_BIT_SET;
        end else begin
          next_op();
        end
      end
      SQ_ACK_REL: begin
        drv_en = 1'b0; drv_sda = 1'b1; wait_units(1); seq_state = SQ_ACK_RISE;
      end
      SQ_ACK_RISE: begin
        drv_scl = 1'b1; wait_units(1); poll_cnt = '0; seq_state = SQ_ACK_POLL;
      end
      SQ_ACK_POLL: begin
        if (!sda_in) begin
          drv_scl = 1'b0; next_op();
        end else if (poll_cnt >= cfg_poll_limit) begin
          ack_err = 1'b1; step_idx = i2c_mra_pkg::AbortStep; seq_state = SQ_STOP_LO;
        end else begin
          poll_cnt = poll_cnt + 8'd1;
        end
      end
      SQ_RD_LOW: begin
        drv_en = 1'b0; drv_scl = 1'b0; wait_units(2); seq_state = SQ_RD_RISE;
      end
      SQ_RD_RISE: begin
        drv_scl = 1'b1;
        shifter = {shifter[6:0], sda_in};
        wait_units(1);
        bit_idx = bit_idx + 4'd1;
        seq_state = (bit_idx < 4'd8) ? SQ_RD_LOW : SQ_RD_DONE;
      end
      SQ_RD_DONE: begin
        rx_byte = shifter; drv_scl = 1'b0; drv_en = 1'b1; drv_sda = !ack_to_send;
        wait_units(2); seq_state = SQ_RD_ACKHI;
      end
      SQ_RD_ACKHI: begin
        drv_scl = 1'b1; wait_units(2); seq_state = SQ_RD_END;
      end
      SQ_RD_END: begin
        drv_scl = 1'b0; next_op();
      end
      SQ_REC_WAIT: begin
        wait_units({16'd0, cfg_recovery}); seq_state = SQ_REC_END;
      end
      SQ_REC_END: next_op();
      default: end_cmd();
    endcase
  endfunction

  function automatic line_status_t next_line_status(input tick_t t);
    line_status_t r;
    cmd_done = 1'b0;
    if (seq_state == SQ_IDLE) begin
      if (t.act != i2c_mra_pkg::ACT_NONE && t.act != i2c_mra_pkg::ACT_UNUSED) begin
        cur_cmd    = t.act;
        op_data    = t.data;
        op_reg     = t.regaddr;
        op_ack     = t.ack;
        ack_err    = 1'b0;
        step_idx   = '0;
        hold_ticks = '0;
        begin_op();
      end
    end else if (hold_ticks != 0) begin
      hold_ticks = hold_ticks - 1;
    end else begin
      run_seq(t.sda);
    end
    r.scl   = drv_scl;
    r.sda   = drv_sda;
    r.drv   = drv_en;
    r.busy  = (seq_state != SQ_IDLE);
    r.done  = cmd_done;
    r.rdata = rx_byte;
    r.aerr  = ack_err;
    return r;
  endfunction

  function automatic void reset_sequencer();
    cfg_tpu = 8'd1; cfg_poll_limit = 8'd250; cfg_dev_addr = 7'd81; cfg_recovery = 16'd10000;
    seq_state = SQ_IDLE; cur_cmd = i2c_mra_pkg::ACT_NONE; step_idx = '0; bit_idx = '0;
    shifter = '0; hold_ticks = '0; poll_cnt = '0; rx_byte = '0; ack_err = 1'b0;
    drv_scl = 1'b1; drv_sda = 1'b1; drv_en = 1'b1;
    op_data = '0; op_reg = '0; op_ack = 1'b0; ack_to_send = 1'b0; cmd_done = 1'b0;
  endfunction

  function automatic tick_t random_tick(input bit refuse_ack);
    tick_t t;
    t.act     = i2c_mra_pkg::action_e'(3'($urandom_range(0, 7)));
    t.data    = 8'($urandom);
    t.regaddr = 8'($urandom);
    t.ack     = 1'($urandom_range(0, 1));
    if (seq_state == SQ_ACK_POLL && refuse_ack) begin
      t.sda = 1'b1;
    end else begin
      t.sda = 1'($urandom_range(0, 1));
    end
    return t;
  endfunction

  task automatic send_tick(input tick_t t);
    int unsigned gap;
    gap = src_gaps ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, t.sda, t.ack, t.regaddr, t.data, t.act};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    line_status_due.push_back(next_line_status(t));
    ticks_sent++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (line_status_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic apply_setting(input logic [7:0] tpu, input logic [7:0] poll_limit,
                               input logic [6:0] dev_addr, input logic [15:0] recovery);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= i2c_mra_pkg::CfgTicksPerUnit;
    cfg_data_i <= {8'd0, tpu};
    @(posedge clk_i);
    cfg_idx_i  <= i2c_mra_pkg::CfgAckPollLimit;
    cfg_data_i <= {8'd0, poll_limit};
    @(posedge clk_i);
    cfg_idx_i  <= i2c_mra_pkg::CfgDeviceAddress;
    cfg_data_i <= {9'd0, dev_addr};
    @(posedge clk_i);
    cfg_idx_i  <= i2c_mra_pkg::CfgWriteRecovery;
    cfg_data_i <= recovery;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_tpu        = tpu;
    cfg_poll_limit = poll_limit;
    cfg_dev_addr   = dev_addr;
    cfg_recovery   = recovery;
  endtask

  task automatic idle_ticks(input int unsigned n);
    tick_t t;
    repeat (n) begin
      t = random_tick(1'b0);
      t.act = $urandom_range(0, 1) ? i2c_mra_pkg::ACT_UNUSED : i2c_mra_pkg::ACT_NONE;
      send_tick(t);
    end
  endtask

  task automatic run_cmd(input i2c_mra_pkg::action_e act, input logic [7:0] data,
                         input logic [7:0] regaddr, input logic ack, input bit refuse_ack);
    tick_t t;
    t = random_tick(refuse_ack);
    t.act     = act;
    t.data    = data;
    t.regaddr = regaddr;
    t.ack     = ack;
    send_tick(t);
    while (seq_state != SQ_IDLE) send_tick(random_tick(refuse_ack));
  endtask

  task automatic test_reset_defaults();
    idle_ticks(3);
    run_cmd(i2c_mra_pkg::ACT_START, 8'h00, 8'h00, 1'b0, 1'b0);
    run_cmd(i2c_mra_pkg::ACT_WRITE, 8'hA2, 8'h00, 1'b0, 1'b0);
    run_cmd(i2c_mra_pkg::ACT_STOP, 8'h00, 8'h00, 1'b0, 1'b0);
  endtask

  task automatic test_each_command();
    drain();
    apply_setting(8'd0, 8'd3, 7'h7F, 16'hFFFF);
    run_cmd(i2c_mra_pkg::ACT_START, 8'h00, 8'h00, 1'b0, 1'b0);
    run_cmd(i2c_mra_pkg::ACT_WRITE, 8'hFF, 8'hFF, 1'b1, 1'b0);
    run_cmd(i2c_mra_pkg::ACT_READ, 8'h00, 8'h00, 1'b1, 1'b0);
    run_cmd(i2c_mra_pkg::ACT_STOP, 8'h00, 8'h00, 1'b0, 1'b0);
    run_cmd(i2c_mra_pkg::ACT_REG_READ, 8'h00, 8'hFF, 1'b1, 1'b0);
    run_cmd(i2c_mra_pkg::ACT_REG_WRITE, 8'hA5, 8'h00, 1'b0, 1'b0);
    idle_ticks(2);
  endtask

  task automatic test_ack_timeout();
    drain();
    apply_setting(8'd0, 8'd0, 7'h00, 16'd0);
    run_cmd(i2c_mra_pkg::ACT_WRITE, 8'h5A, 8'h00, 1'b0, 1'b1);
    run_cmd(i2c_mra_pkg::ACT_REG_READ, 8'h00, 8'h3C, 1'b0, 1'b1);
    drain();
    apply_setting(8'd0, 8'd255, 7'h2A, 16'd0);
    run_cmd(i2c_mra_pkg::ACT_WRITE, 8'hC3, 8'h00, 1'b0, 1'b1);
  endtask

  task automatic test_slow_timebase();
    drain();
    apply_setting(8'd20, 8'd2, 7'h51, 16'd3);
    run_cmd(i2c_mra_pkg::ACT_STOP, 8'h00, 8'h00, 1'b0, 1'b0);
    drain();
    apply_setting(8'd2, 8'd4, 7'h13, 16'd7);
    run_cmd(i2c_mra_pkg::ACT_READ, 8'h00, 8'h0D, 1'b1, 1'b0);
  endtask

  task automatic test_output_backpressure();
    drain();
    apply_setting(8'd0, 8'd8, 7'h51, 16'd5);
    src_gaps    = 1'b0;
    sink_stalls = 1'b0;
    hold_off    = 300;
    run_cmd(i2c_mra_pkg::ACT_REG_READ, 8'h00, 8'h02, 1'b0, 1'b0);
    src_gaps    = 1'b1;
    sink_stalls = 1'b1;
  endtask

  task automatic test_random_traffic();
    int unsigned          pick;
    i2c_mra_pkg::action_e act;
    while (ticks_sent < ItemTarget) begin
      if ($urandom_range(0, 5) == 0) begin
        drain();
        apply_setting(($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 2)) : 8'd0,
                      ($urandom_range(0, 7) == 0) ? 8'd255 : 8'($urandom_range(0, 6)),
                      7'($urandom_range(0, 127)), 16'($urandom_range(0, 40)));
      end
      src_gaps    = ($urandom_range(0, 3) != 0);
      sink_stalls = ($urandom_range(0, 3) != 0);
      idle_ticks($urandom_range(0, 2));
      pick = $urandom_range(0, 9);
      case (pick)
        0, 1, 2, 3: act = i2c_mra_pkg::ACT_REG_READ;
        4, 5, 6:    act = i2c_mra_pkg::ACT_REG_WRITE;
        7:          act = i2c_mra_pkg::ACT_WRITE;
        8:          act = i2c_mra_pkg::ACT_READ;
        default:    act = $urandom_range(0, 1) ? i2c_mra_pkg::ACT_START
                                                : i2c_mra_pkg::ACT_STOP;
      endcase
      run_cmd(act, 8'($urandom), 8'($urandom), 1'($urandom_range(0, 1)),
              ($urandom_range(0, 9) == 0));
    end
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
    end
  endtask

  initial begin : result_checker
    line_status_t want;
    int unsigned  stall;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = sink_stalls ? $urandom_range(0, 15) : 0;
      if (hold_off != 0) begin
        stall = hold_off;
        hold_off = 0;
      end
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_axis_tvalid) @(posedge clk_i);
      if (line_status_due.size() == 0) begin
        errors++;
        $display("%0t: output transfer %h with nothing expected", $time, m_axis_tdata);
      end else begin
        want = line_status_due.pop_front();
        check_field("scl_out", {7'd0, want.scl}, {7'd0, m_axis_tdata[0]});
        check_field("sda_out", {7'd0, want.sda}, {7'd0, m_axis_tdata[1]});
        check_field("sda_drive", {7'd0, want.drv}, {7'd0, m_axis_tdata[2]});
        check_field("busy", {7'd0, want.busy}, {7'd0, m_axis_tdata[3]});
        check_field("done", {7'd0, want.done}, {7'd0, m_axis_tdata[4]});
        check_field("read_data", want.rdata, m_axis_tdata[12:5]);
        check_field("ack_error", {7'd0, want.aerr}, {7'd0, m_axis_tdata[13]});
      end
    end
  end

  initial begin : watchdog
    wait (cycle_count >= CycleLimit);
    $display("i2c_master_register_access: mismatch");
    $finish;
  end

  initial begin : stimulus
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = i2c_mra_pkg::CfgTicksPerUnit;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    reset_sequencer();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_defaults();
    test_each_command();
    test_ack_timeout();
    test_slow_timebase();
    test_output_backpressure();
    test_random_traffic();
    drain();
    repeat (16) @(posedge clk_i);
    if (errors == 0) begin
      $display("i2c_master_register_access: match");
    end else begin
      $display("i2c_master_register_access: mismatch");
    end
    $finish;
  end

endmodule

[sim.f]
src/i2c_mra_pkg.sv
src/i2c_master_register_access.sv
dv/testbench.sv
